@@ rtl/pfpl_pkg.sv @@
`default_nettype none

package pfpl_pkg;

  // shifts and integral bounds
  localparam int GAIN_SHIFT   = 8;
  localparam int GUARD_SHIFT  = 4;
  localparam int INTEGRAL_MAX = 1048575;
  localparam int INTEGRAL_MIN = -1048576;
  localparam int GUARD        = 1 << GUARD_SHIFT;
  localparam int HALF_GUARD   = GUARD / 2;

  // field and datapath widths
  localparam int GAIN_W  = 15;
  localparam int LIMIT_W = 16;
  localparam int FLOW_W  = 16;
  localparam int OUT_W   = 15;
  localparam int ERR_W   = 17;
  localparam int DER_W   = 19;
  localparam int PD_W    = 18;
  localparam int FRAC_W  = 15;
  localparam int INT_W   = 32;
  localparam int ISUM_W  = 49;
  localparam int OPA_W   = 32;
  localparam int OPB_W   = 16;
  localparam int PROD_W  = 48;
  localparam int ACC_W   = 50;
  localparam int DRV_W   = 52;
  localparam int PC_W    = 5;

  // microprogram entry points
  localparam logic [PC_W-1:0] PC_GUARD  = 5'd8;
  localparam logic [PC_W-1:0] PC_INTEG  = 5'd9;
  localparam logic [PC_W-1:0] PC_PRESS  = 5'd12;
  localparam logic [PC_W-1:0] PC_FINISH = 5'd18;

  typedef struct packed {
    logic [GAIN_W-1:0]  prop_gain;
    logic [GAIN_W-1:0]  integ_gain;
    logic [GAIN_W-1:0]  deriv_gain;
    logic [GAIN_W-1:0]  press_prop_gain;
    logic [GAIN_W-1:0]  press_integ_gain;
    logic [GAIN_W-1:0]  press_deriv_gain;
    logic [LIMIT_W-1:0] pressure_limit;
    logic [GAIN_W-1:0]  max_flow;
  } cfg_t;

  typedef enum logic [1:0] {
    MODE_FLOW  = 2'd0,
    MODE_GUARD = 2'd1,
    MODE_PRESS = 2'd2
  } mode_t;

  typedef enum logic [3:0] {
    ALU_NOP,
    ALU_PREP1,
    ALU_PREP2,
    ALU_ACC_LD,
    ALU_ACC_ADD,
    ALU_DRV_INIT,
    ALU_DRV_ADD,
    ALU_INT_E,
    ALU_INT_SHR,
    ALU_INT_PROD,
    ALU_FINISH
  } alu_op_t;

  typedef enum logic [2:0] {
    A_E,
    A_D,
    A_PE,
    A_PD,
    A_INT
  } a_sel_t;

  typedef enum logic [2:0] {
    B_KP,
    B_KD,
    B_KPP,
    B_KPD,
    B_KI,
    B_PIG,
    B_FRAC
  } b_sel_t;

  typedef enum logic [2:0] {
    J_SEQ,
    J_GOTO,
    J_IF_M1,
    J_IF_M2,
    J_DONE
  } jmp_t;

  typedef struct packed {
    alu_op_t          alu;
    logic             mul_en;
    a_sel_t           a_sel;
    b_sel_t           b_sel;
    jmp_t             jmp;
    logic [PC_W-1:0]  target;
  } ucode_t;

  typedef struct packed {
    logic   load;
    logic   step_en;
    ucode_t cw;
  } dp_ctl_t;

  typedef struct packed {
    mode_t mode;
  } dp_stat_t;

  // control store: multiplier result lands one step after its mul_en step
  function automatic ucode_t ucode_rom(input logic [PC_W-1:0] addr);
    ucode_t w;
    w = '{alu: ALU_NOP, mul_en: 1'b0, a_sel: A_E, b_sel: B_KP, jmp: J_SEQ, target: '0};
    case (addr)
      5'd0: w.alu = ALU_PREP1;
      5'd1: w.alu = ALU_PREP2;
      5'd2: begin
        w.mul_en = 1'b1; w.a_sel = A_E; w.b_sel = B_KP;
      end
      5'd3: begin
        w.alu = ALU_ACC_LD; w.mul_en = 1'b1; w.a_sel = A_D; w.b_sel = B_KD;
      end
      5'd4: begin
        w.alu = ALU_ACC_ADD; w.mul_en = 1'b1; w.a_sel = A_E; w.b_sel = B_FRAC;
      end
      5'd5: begin
        w.alu = ALU_DRV_INIT; w.jmp = J_IF_M2; w.target = PC_PRESS;
      end
      5'd6: begin
        w.jmp = J_IF_M1; w.target = PC_GUARD;
      end
      5'd7: begin
        w.alu = ALU_INT_E; w.jmp = J_GOTO; w.target = PC_INTEG;
      end
      5'd8: w.alu = ALU_INT_SHR;
      5'd9: begin
        w.mul_en = 1'b1; w.a_sel = A_INT; w.b_sel = B_KI;
      end
      5'd10: w.alu = ALU_ACC_LD;
      5'd11: begin
        w.alu = ALU_DRV_ADD; w.jmp = J_GOTO; w.target = PC_FINISH;
      end
      5'd12: begin
        w.mul_en = 1'b1; w.a_sel = A_PE; w.b_sel = B_PIG;
      end
      5'd13: begin
        w.alu = ALU_INT_PROD; w.mul_en = 1'b1; w.a_sel = A_PE; w.b_sel = B_KPP;
      end
      5'd14: begin
        w.alu = ALU_ACC_LD; w.mul_en = 1'b1; w.a_sel = A_INT; w.b_sel = B_KI;
      end
      5'd15: begin
        w.alu = ALU_ACC_ADD; w.mul_en = 1'b1; w.a_sel = A_PD; w.b_sel = B_KPD;
      end
      5'd16: w.alu = ALU_ACC_ADD;
      5'd17: w.alu = ALU_DRV_ADD;
      5'd18: begin
        w.alu = ALU_FINISH; w.jmp = J_DONE;
      end
      default: w.jmp = J_GOTO;
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

@@ rtl/pid_flow_pressure_limit.sv @@
`default_nettype none

// channel  direction  handshake                 payload
// in       slave      in_valid / in_stall       target_flow, measured_flow,
//                                               measured_pressure, clear_integral
// out      master     out_valid / out_stall     drive_flow, regulation_mode
// cfg      apb slave  psel penable pwrite pready 8 registers at 4*i, 32-bit data
//
// requests do not overlap: after the accept cycle, 12 microcode steps run in flow and
// guard-band modes and 13 in pressure mode, all on the one shared multiplier.
// in_stall stays high from accept until the last step retires.
// the last step waits while the previous result is still stalled at the output.
// synchronous active-low reset clears the loop state and restores register defaults.
module pid_flow_pressure_limit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [15:0] in_target_flow,
  input  wire logic [15:0] in_measured_flow,
  input  wire logic [15:0] in_measured_pressure,
  input  wire logic        in_clear_integral,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [14:0]      out_drive_flow,
  output logic [1:0]       out_regulation_mode,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  typedef enum logic [2:0] {
    REG_PROP_GAIN,
    REG_INTEG_GAIN,
    REG_DERIV_GAIN,
    REG_PRESS_PROP_GAIN,
    REG_PRESS_INTEG_GAIN,
    REG_PRESS_DERIV_GAIN,
    REG_PRESSURE_LIMIT,
    REG_MAX_FLOW
  } reg_idx_t;

  pfpl_pkg::cfg_t     cfg_r;
  reg_idx_t           idx;
  logic               wr;
  pfpl_pkg::dp_ctl_t  ctl;
  pfpl_pkg::dp_stat_t stat;

  assign idx    = reg_idx_t'(paddr[4:2]);
  assign wr     = psel & penable & pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.prop_gain        <= '0;
      cfg_r.integ_gain       <= '0;
      cfg_r.deriv_gain       <= '0;
      cfg_r.press_prop_gain  <= '0;
      cfg_r.press_integ_gain <= '0;
      cfg_r.press_deriv_gain <= '0;
      cfg_r.pressure_limit   <= '0;
      cfg_r.max_flow         <= '1;
    end else if (wr) begin
      unique case (idx)
        REG_PROP_GAIN:        cfg_r.prop_gain        <= pwdata[14:0];
        REG_INTEG_GAIN:       cfg_r.integ_gain       <= pwdata[14:0];
        REG_DERIV_GAIN:       cfg_r.deriv_gain       <= pwdata[14:0];
        REG_PRESS_PROP_GAIN:  cfg_r.press_prop_gain  <= pwdata[14:0];
        REG_PRESS_INTEG_GAIN: cfg_r.press_integ_gain <= pwdata[14:0];
        REG_PRESS_DERIV_GAIN: cfg_r.press_deriv_gain <= pwdata[14:0];
        REG_PRESSURE_LIMIT:   cfg_r.pressure_limit   <= pwdata[15:0];
        REG_MAX_FLOW:         cfg_r.max_flow         <= pwdata[14:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_PROP_GAIN:        prdata = {17'b0, cfg_r.prop_gain};
      REG_INTEG_GAIN:       prdata = {17'b0, cfg_r.integ_gain};
      REG_DERIV_GAIN:       prdata = {17'b0, cfg_r.deriv_gain};
      REG_PRESS_PROP_GAIN:  prdata = {17'b0, cfg_r.press_prop_gain};
      REG_PRESS_INTEG_GAIN: prdata = {17'b0, cfg_r.press_integ_gain};
      REG_PRESS_DERIV_GAIN: prdata = {17'b0, cfg_r.press_deriv_gain};
      REG_PRESSURE_LIMIT:   prdata = {16'b0, cfg_r.pressure_limit};
      REG_MAX_FLOW:         prdata = {17'b0, cfg_r.max_flow};
      default:              prdata = '0;
    endcase
  end

  pfpl_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .ctl       (ctl)
  );

  pfpl_datapath u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .ctl               (ctl),
    .cfg               (cfg_r),
    .target_flow       (in_target_flow),
    .measured_flow     (in_measured_flow),
    .measured_pressure (in_measured_pressure),
    .clear_integral    (in_clear_integral),
    .stat              (stat),
    .drive_flow        (out_drive_flow),
    .regulation_mode   (out_regulation_mode)
  );

endmodule

`default_nettype wire

@@ rtl/pfpl_seq.sv @@
`default_nettype none

module pfpl_seq (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  output logic                   out_valid,
  input  wire logic              out_stall,
  input  wire pfpl_pkg::dp_stat_t stat,
  output pfpl_pkg::dp_ctl_t      ctl
);

  logic [pfpl_pkg::PC_W-1:0] pc_r, pc_nxt, pc_inc;
  logic                      busy_r;
  logic                      out_valid_r;
  pfpl_pkg::ucode_t          cw;
  logic                      accept;
  logic                      done;
  logic                      hold;
  logic                      step_en;

  assign cw      = pfpl_pkg::ucode_rom(pc_r);
  assign accept  = in_valid & ~busy_r;
  assign done    = (cw.jmp == pfpl_pkg::J_DONE);
  // last step waits while the previous result is still unclaimed
  assign hold    = done & out_valid_r & out_stall;
  assign step_en = busy_r & ~hold;
  assign pc_inc  = pc_r + pfpl_pkg::PC_W'(1);

  always_comb begin
    unique case (cw.jmp)
      pfpl_pkg::J_GOTO:  pc_nxt = cw.target;
      pfpl_pkg::J_IF_M1: pc_nxt = (stat.mode == pfpl_pkg::MODE_GUARD) ? cw.target : pc_inc;
      pfpl_pkg::J_IF_M2: pc_nxt = (stat.mode == pfpl_pkg::MODE_PRESS) ? cw.target : pc_inc;
      pfpl_pkg::J_DONE:  pc_nxt = pc_r;
      default:           pc_nxt = pc_inc;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= '0;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        busy_r <= 1'b1;
        pc_r   <= '0;
      end else if (step_en) begin
        pc_r <= pc_nxt;
        if (done) begin
          busy_r <= 1'b0;
        end
      end
      if (step_en && done) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign in_stall    = busy_r;
  assign out_valid   = out_valid_r;
  assign ctl.load    = accept;
  assign ctl.step_en = step_en;
  assign ctl.cw      = cw;

endmodule

`default_nettype wire

@@ rtl/pfpl_datapath.sv @@
`default_nettype none

module pfpl_datapath (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire pfpl_pkg::dp_ctl_t             ctl,
  input  wire pfpl_pkg::cfg_t                cfg,
  input  wire logic [pfpl_pkg::FLOW_W-1:0]   target_flow,
  input  wire logic [pfpl_pkg::FLOW_W-1:0]   measured_flow,
  input  wire logic [pfpl_pkg::LIMIT_W-1:0]  measured_pressure,
  input  wire logic                          clear_integral,
  output pfpl_pkg::dp_stat_t                 stat,
  output logic [pfpl_pkg::OUT_W-1:0]         drive_flow,
  output logic [1:0]                         regulation_mode
);

  localparam int ERR_W  = pfpl_pkg::ERR_W;
  localparam int PD_W   = pfpl_pkg::PD_W;
  localparam int DER_W  = pfpl_pkg::DER_W;
  localparam int ISUM_W = pfpl_pkg::ISUM_W;
  localparam int ACC_W  = pfpl_pkg::ACC_W;
  localparam int DRV_W  = pfpl_pkg::DRV_W;
  localparam int INT_W  = pfpl_pkg::INT_W;

  localparam logic signed [ERR_W-1:0]  GUARD_V = ERR_W'(pfpl_pkg::GUARD);
  localparam logic signed [PD_W-1:0]   HALF_V  = PD_W'(pfpl_pkg::HALF_GUARD);
  localparam logic signed [ISUM_W-1:0] IMAX    = ISUM_W'(pfpl_pkg::INTEGRAL_MAX);
  localparam logic signed [ISUM_W-1:0] IMIN    = ISUM_W'(pfpl_pkg::INTEGRAL_MIN);

  // latched request
  logic [pfpl_pkg::FLOW_W-1:0]  tgt_r, mflow_r;
  logic [pfpl_pkg::LIMIT_W-1:0] press_r;
  logic                         clr_r;

  // working registers
  logic signed [ERR_W-1:0]              e_r, pe_r;
  logic signed [DER_W-1:0]              d_r;
  logic signed [PD_W-1:0]               pd_r;
  logic [pfpl_pkg::FRAC_W-1:0]          frac_r;
  pfpl_pkg::mode_t                      mode_r;
  logic signed [pfpl_pkg::PROD_W-1:0]   prod_r;
  logic signed [ACC_W-1:0]              acc_r;
  logic signed [DRV_W-1:0]              drv_r;

  // loop state
  logic signed [ERR_W-1:0] last_e_r, older_e_r, last_pe_r;
  logic signed [INT_W-1:0] integ_r;

  logic [pfpl_pkg::OUT_W-1:0] out_drive_r;
  pfpl_pkg::mode_t            out_mode_r;

  logic signed [pfpl_pkg::OPA_W-1:0]  a_w;
  logic signed [pfpl_pkg::OPB_W-1:0]  b_w;
  logic signed [pfpl_pkg::PROD_W-1:0] prod_w;
  logic signed [ERR_W-1:0]            e_w, pe_w;
  logic signed [DER_W-1:0]            d_w;
  logic signed [PD_W-1:0]             pd_w, frac_w;
  pfpl_pkg::mode_t                    mode_w;
  logic signed [ISUM_W-1:0]           iadd_w, isum_w;
  logic signed [INT_W-1:0]            iclamp_w;
  logic signed [DRV_W-1:0]            acc_shr_w;
  logic signed [DRV_W-1:0]            max_w;
  logic [pfpl_pkg::OUT_W-1:0]         drive_w;

  always_comb begin
    unique case (ctl.cw.a_sel)
      pfpl_pkg::A_E:   a_w = pfpl_pkg::OPA_W'(e_r);
      pfpl_pkg::A_D:   a_w = pfpl_pkg::OPA_W'(d_r);
      pfpl_pkg::A_PE:  a_w = pfpl_pkg::OPA_W'(pe_r);
      pfpl_pkg::A_PD:  a_w = pfpl_pkg::OPA_W'(pd_r);
      pfpl_pkg::A_INT: a_w = integ_r;
      default:         a_w = '0;
    endcase
    unique case (ctl.cw.b_sel)
      pfpl_pkg::B_KP:   b_w = {1'b0, cfg.prop_gain};
      pfpl_pkg::B_KD:   b_w = {1'b0, cfg.deriv_gain};
      pfpl_pkg::B_KPP:  b_w = {1'b0, cfg.press_prop_gain};
      pfpl_pkg::B_KPD:  b_w = {1'b0, cfg.press_deriv_gain};
      pfpl_pkg::B_KI:   b_w = {1'b0, cfg.integ_gain};
      pfpl_pkg::B_PIG:  b_w = {1'b0, cfg.press_integ_gain};
      pfpl_pkg::B_FRAC: b_w = {1'b0, frac_r};
      default:          b_w = '0;
    endcase
  end

  assign prod_w = a_w * b_w;

  assign e_w  = $signed({1'b0, tgt_r}) - $signed({1'b0, mflow_r});
  assign pe_w = $signed({1'b0, cfg.pressure_limit}) - $signed({1'b0, press_r});
  // two-step smoothed derivative
  assign d_w  = (DER_W'(e_r) - DER_W'(last_e_r)) + (DER_W'(e_r) - DER_W'(older_e_r));
  assign pd_w = PD_W'(pe_r) - PD_W'(last_pe_r);
  assign frac_w = PD_W'(pe_r) - HALF_V;

  always_comb begin
    if (pe_r >= GUARD_V) begin
      mode_w = pfpl_pkg::MODE_FLOW;
    end else if (pe_r > $signed(ERR_W'(0))) begin
      mode_w = pfpl_pkg::MODE_GUARD;
    end else begin
      mode_w = pfpl_pkg::MODE_PRESS;
    end
  end

  always_comb begin
    unique case (ctl.cw.alu)
      pfpl_pkg::ALU_INT_SHR:  iadd_w = ISUM_W'(prod_r >>> pfpl_pkg::GUARD_SHIFT);
      pfpl_pkg::ALU_INT_PROD: iadd_w = ISUM_W'(prod_r);
      default:                iadd_w = ISUM_W'(e_r);
    endcase
  end

  assign isum_w = ISUM_W'(integ_r) + iadd_w;

  always_comb begin
    if (isum_w > IMAX) begin
      iclamp_w = INT_W'(IMAX);
    end else if (isum_w < IMIN) begin
      iclamp_w = INT_W'(IMIN);
    end else begin
      iclamp_w = INT_W'(isum_w);
    end
  end

  assign acc_shr_w = DRV_W'(acc_r >>> pfpl_pkg::GAIN_SHIFT);
  assign max_w     = $signed(DRV_W'({1'b0, cfg.max_flow}));

  always_comb begin
    if (drv_r[DRV_W-1]) begin
      drive_w = '0;
    end else if (drv_r > max_w) begin
      drive_w = cfg.max_flow;
    end else begin
      drive_w = drv_r[pfpl_pkg::OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      tgt_r   <= target_flow;
      mflow_r <= measured_flow;
      press_r <= measured_pressure;
      clr_r   <= clear_integral;
    end
    if (ctl.step_en && ctl.cw.mul_en) begin
      prod_r <= prod_w;
    end
    if (ctl.step_en) begin
      unique case (ctl.cw.alu)
        pfpl_pkg::ALU_PREP1: begin
          e_r  <= e_w;
          pe_r <= pe_w;
        end
        pfpl_pkg::ALU_PREP2: begin
          d_r    <= d_w;
          pd_r   <= pd_w;
          mode_r <= mode_w;
          frac_r <= frac_w[PD_W-1] ? '0 : frac_w[pfpl_pkg::FRAC_W-1:0];
        end
        pfpl_pkg::ALU_ACC_LD:   acc_r <= ACC_W'(prod_r);
        pfpl_pkg::ALU_ACC_ADD:  acc_r <= acc_r + ACC_W'(prod_r);
        pfpl_pkg::ALU_DRV_INIT: drv_r <= $signed(DRV_W'({1'b0, tgt_r})) + acc_shr_w;
        pfpl_pkg::ALU_DRV_ADD:  drv_r <= drv_r + acc_shr_w;
        pfpl_pkg::ALU_FINISH: begin
          out_drive_r <= drive_w;
          out_mode_r  <= mode_r;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_e_r  <= '0;
      older_e_r <= '0;
      last_pe_r <= '0;
      integ_r   <= '0;
    end else if (ctl.step_en) begin
      unique case (ctl.cw.alu) inside
        pfpl_pkg::ALU_INT_E, pfpl_pkg::ALU_INT_SHR, pfpl_pkg::ALU_INT_PROD: begin
          integ_r <= iclamp_w;
        end
        pfpl_pkg::ALU_FINISH: begin
          older_e_r <= last_e_r;
          last_e_r  <= e_r;
          last_pe_r <= pe_r;
          if (clr_r) begin
            integ_r <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  assign stat.mode       = mode_r;
  assign drive_flow      = out_drive_r;
  assign regulation_mode = out_mode_r;

endmodule

`default_nettype wire

@@ rtl/pfpl_checker.sv @@
`default_nettype none

module pfpl_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_stall,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [1:0] out_regulation_mode
);

  // a taken request keeps the input closed while it is worked on
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input open right after a request was taken");

  // the input reopens only as a result is presented
  a_result_on_release: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(in_stall) |-> out_valid)
    else $error("input reopened without a result");

  a_mode_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_regulation_mode != 2'd3)
    else $error("regulation mode out of range");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("stalled result dropped");

endmodule

bind pid_flow_pressure_limit pfpl_checker u_pfpl_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_valid            (in_valid),
  .in_stall            (in_stall),
  .out_valid           (out_valid),
  .out_stall           (out_stall),
  .out_regulation_mode (out_regulation_mode)
);

`default_nettype wire
